FILE: src/ogu_pkg.sv
// Shared types, constants and helpers for the occupancy grid update core.
`default_nettype none

package ogu_pkg;

	// Grid geometry
	localparam int unsigned GRID_COLS  = 512;
	localparam int unsigned GRID_ROWS  = 512;
	localparam int unsigned GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int unsigned ADDR_W     = $clog2(GRID_CELLS);

	// Field widths
	localparam int unsigned IDX_W    = 18;
	localparam int unsigned MM_W     = 16;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned PROD_W   = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned CELL_W   = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_W    = 48;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned OFFS_W   = 32;

	// Fixed point: 16 fraction bits in the accumulator, offset carries 8
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned OFFS_SH = 8;
	localparam int unsigned ACC_W   = 41;
	localparam int unsigned COORD_W = ACC_W - FRAC_W;
	localparam int unsigned HALF    = 32768;

	localparam logic signed [MM_W-1:0] FLOOR_LIMIT_MM = -16'sd1000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COL_COEFFS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COEFFS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GROUND_LIM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OBST_LIM   = 3'd5;

	// Register reset values
	localparam logic [CFG_W-1:0]         RST_COL_COEFFS = 48'd1311;
	localparam logic [CFG_W-1:0]         RST_ROW_COEFFS = 48'd85917696;
	localparam logic signed [OFFS_W-1:0] RST_COL_OFFSET = 32'sd65536;
	localparam logic signed [OFFS_W-1:0] RST_ROW_OFFSET = 32'sd65536;
	localparam logic signed [MM_W-1:0]   RST_GROUND_LIM = 16'sd150;
	localparam logic signed [MM_W-1:0]   RST_OBST_LIM   = 16'sd250;

	// Opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Cell states
	localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREE      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 3'd4;
	localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;

	// Projected item leaving the projection pipeline
	typedef struct packed {
		logic                      valid;
		logic                      op;
		logic                      fin;
		logic [IDX_W-1:0]          ridx;
		logic                      ground;
		logic                      obst;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
	} proj_item_t;

	// Grid memory access request
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CELL_W-1:0] wr_data;
	} grid_req_t;

	// Round half away from zero of acc / 2^16
	function automatic logic signed [COORD_W-1:0] round_cells(
		input logic signed [ACC_W-1:0] acc
	);
		logic [ACC_W-1:0]        bias;
		logic signed [ACC_W-1:0] r;
		bias = acc[ACC_W-1] ? ACC_W'(HALF - 1) : ACC_W'(HALF);
		r = acc + $signed(bias);
		return r[ACC_W-1:FRAC_W];
	endfunction

endpackage

`default_nettype wire

FILE: src/ogu_proj.sv
// Height classification and fixed-point projection pipeline (stages 1 to 4).
`default_nettype none

module ogu_proj (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               accept,
	input  wire logic                               opcode,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_x_mm,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_y_mm,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_z_mm,
	input  wire logic                               point_finite,
	input  wire logic [ogu_pkg::IDX_W-1:0]          read_index,
	input  wire logic [ogu_pkg::CFG_W-1:0]          col_coeffs,
	input  wire logic [ogu_pkg::CFG_W-1:0]          row_coeffs,
	input  wire logic signed [ogu_pkg::OFFS_W-1:0]  col_offset,
	input  wire logic signed [ogu_pkg::OFFS_W-1:0]  row_offset,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    ground_limit_mm,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    obstacle_limit_mm,
	output ogu_pkg::proj_item_t                     item
);

	// Stage 1: captured input
	logic                            v_s1, op_s1, fin_s1;
	logic [ogu_pkg::IDX_W-1:0]       ridx_s1;
	logic signed [ogu_pkg::MM_W-1:0] x_s1, y_s1, z_s1;

	// Stage 2: class and products
	logic                              v_s2, op_s2, fin_s2, ground_s2, obst_s2;
	logic [ogu_pkg::IDX_W-1:0]         ridx_s2;
	logic signed [ogu_pkg::PROD_W-1:0] cpx_s2, cpy_s2, cpz_s2;
	logic signed [ogu_pkg::PROD_W-1:0] rpx_s2, rpy_s2, rpz_s2;

	// Stage 3: accumulators
	logic                             v_s3, op_s3, fin_s3, ground_s3, obst_s3;
	logic [ogu_pkg::IDX_W-1:0]        ridx_s3;
	logic signed [ogu_pkg::ACC_W-1:0] cacc_s3, racc_s3;

	// Stage 4: rounded cell coordinates
	logic                               v_s4, op_s4, fin_s4, ground_s4, obst_s4;
	logic [ogu_pkg::IDX_W-1:0]          ridx_s4;
	logic signed [ogu_pkg::COORD_W-1:0] col_s4, row_s4;

	// Coefficient fields
	logic signed [ogu_pkg::COEF_W-1:0] ccx, ccy, ccz, rcx, rcy, rcz;
	logic signed [ogu_pkg::ACC_W-1:0]  coff, roff;
	logic                              is_ground, is_obst;

	assign ccx = $signed(col_coeffs[15:0]);
	assign ccy = $signed(col_coeffs[31:16]);
	assign ccz = $signed(col_coeffs[47:32]);
	assign rcx = $signed(row_coeffs[15:0]);
	assign rcy = $signed(row_coeffs[31:16]);
	assign rcz = $signed(row_coeffs[47:32]);

	// Offsets are in 1/256 cell, accumulator in 1/65536 cell
	assign coff = ogu_pkg::ACC_W'($signed({col_offset, {ogu_pkg::OFFS_SH{1'b0}}}));
	assign roff = ogu_pkg::ACC_W'($signed({row_offset, {ogu_pkg::OFFS_SH{1'b0}}}));

	// Height classes; obstacle wins when both hold
	assign is_ground = (z_s1 < ground_limit_mm) && (z_s1 > ogu_pkg::FLOOR_LIMIT_MM);
	assign is_obst   = z_s1 > obstacle_limit_mm;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= opcode;
			fin_s1  <= point_finite;
			ridx_s1 <= read_index;
			x_s1    <= point_x_mm;
			y_s1    <= point_y_mm;
			z_s1    <= point_z_mm;

			op_s2     <= op_s1;
			fin_s2    <= fin_s1;
			ridx_s2   <= ridx_s1;
			ground_s2 <= is_ground;
			obst_s2   <= is_obst;
			cpx_s2    <= ccx * x_s1;
			cpy_s2    <= ccy * y_s1;
			cpz_s2    <= ccz * z_s1;
			rpx_s2    <= rcx * x_s1;
			rpy_s2    <= rcy * y_s1;
			rpz_s2    <= rcz * z_s1;

			op_s3     <= op_s2;
			fin_s3    <= fin_s2;
			ridx_s3   <= ridx_s2;
			ground_s3 <= ground_s2;
			obst_s3   <= obst_s2;
			cacc_s3   <= ogu_pkg::ACC_W'(cpx_s2) + ogu_pkg::ACC_W'(cpy_s2)
				+ ogu_pkg::ACC_W'(cpz_s2) + coff;
			racc_s3   <= ogu_pkg::ACC_W'(rpx_s2) + ogu_pkg::ACC_W'(rpy_s2)
				+ ogu_pkg::ACC_W'(rpz_s2) + roff;

			op_s4     <= op_s3;
			fin_s4    <= fin_s3;
			ridx_s4   <= ridx_s3;
			ground_s4 <= ground_s3;
			obst_s4   <= obst_s3;
			col_s4    <= ogu_pkg::round_cells(cacc_s3);
			row_s4    <= ogu_pkg::round_cells(racc_s3);
		end
	end

	assign item.valid  = v_s4;
	assign item.op     = op_s4;
	assign item.fin    = fin_s4;
	assign item.ridx   = ridx_s4;
	assign item.ground = ground_s4;
	assign item.obst   = obst_s4;
	assign item.col    = col_s4;
	assign item.row    = row_s4;

endmodule

`default_nettype wire

FILE: src/ogu_grid.sv
// Grid cell memory with a registered read and a clearing pass after reset.
`default_nettype none

module ogu_grid (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  ogu_pkg::grid_req_t                req,
	output logic [ogu_pkg::CELL_W-1:0]        rd_data,
	output logic                              clearing
);

	localparam logic [ogu_pkg::ADDR_W-1:0] LAST_ADDR =
		ogu_pkg::ADDR_W'(ogu_pkg::GRID_CELLS - 1);

	logic [ogu_pkg::CELL_W-1:0] mem [ogu_pkg::GRID_CELLS];
	logic [ogu_pkg::CELL_W-1:0] rd_data_q;
	logic                       clr_active_q;
	logic [ogu_pkg::ADDR_W-1:0] clr_addr_q;

	// Clear sweep: one cell per cycle from address zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Memory port: read returns the old value on a same-cycle write
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
		if (clr_active_q) begin
			mem[clr_addr_q] <= ogu_pkg::CELL_UNKNOWN;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_active_q;

	a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> $past(clr_addr_q) == LAST_ADDR)
		else $error("clear pass ended before the last cell");

	a_clear_done_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_active_q |=> !clr_active_q)
		else $error("clear pass restarted without reset");

	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !req.wr_en)
		else $error("cell update requested during clear pass");

endmodule

`default_nettype wire

FILE: src/point_to_occupancy_grid_update_core.sv
// Top level: config registers, bounds and index stage, grid read-modify-write, counters.
// Pipeline: an input transfer passes through 4 projection stages, one index/read stage,
// one update stage, then the output register.
// Throughput: one item per cycle unless out_stall or the clear pass stalls the input;
// back-to-back updates of the same cell are forwarded from the last grid write into the
// update stage. Reset: counters and registers take their reset values at once; the grid
// is then swept to unknown cell by cell, with in_stall high meanwhile.
`default_nettype none

module point_to_occupancy_grid_update_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [ogu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ogu_pkg::CFG_W-1:0]          cfg_wdata,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               opcode,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_x_mm,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_y_mm,
	input  wire logic signed [ogu_pkg::MM_W-1:0]    point_z_mm,
	input  wire logic                               point_finite,
	input  wire logic [ogu_pkg::IDX_W-1:0]          read_index,
	// output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ogu_pkg::STATUS_W-1:0]            status,
	output logic [ogu_pkg::IDX_W-1:0]               cell_index,
	output logic [ogu_pkg::CELL_W-1:0]              cell_value,
	output logic [ogu_pkg::CNT_W-1:0]               points_processed,
	output logic [ogu_pkg::CNT_W-1:0]               ground_updates,
	output logic [ogu_pkg::CNT_W-1:0]               obstacle_updates
);

	// Configuration registers
	logic [ogu_pkg::CFG_W-1:0]         col_coeffs_q, row_coeffs_q;
	logic signed [ogu_pkg::OFFS_W-1:0] col_offset_q, row_offset_q;
	logic signed [ogu_pkg::MM_W-1:0]   ground_lim_q, obst_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_coeffs_q <= ogu_pkg::RST_COL_COEFFS;
			row_coeffs_q <= ogu_pkg::RST_ROW_COEFFS;
			col_offset_q <= ogu_pkg::RST_COL_OFFSET;
			row_offset_q <= ogu_pkg::RST_ROW_OFFSET;
			ground_lim_q <= ogu_pkg::RST_GROUND_LIM;
			obst_lim_q   <= ogu_pkg::RST_OBST_LIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogu_pkg::REG_COL_COEFFS: col_coeffs_q <= cfg_wdata;
				ogu_pkg::REG_ROW_COEFFS: row_coeffs_q <= cfg_wdata;
				ogu_pkg::REG_COL_OFFSET: col_offset_q <= $signed(cfg_wdata[31:0]);
				ogu_pkg::REG_ROW_OFFSET: row_offset_q <= $signed(cfg_wdata[31:0]);
				ogu_pkg::REG_GROUND_LIM: ground_lim_q <= $signed(cfg_wdata[15:0]);
				ogu_pkg::REG_OBST_LIM:   obst_lim_q   <= $signed(cfg_wdata[15:0]);
				default: ;
			endcase
		end
	end

	// Handshake: whole pipeline moves when the output register can take a result
	logic adv, accept, clearing, out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv || clearing;
	assign accept   = in_valid && !in_stall;

	// Projection pipeline
	ogu_pkg::proj_item_t item;

	ogu_proj u_proj (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.accept            (accept),
		.opcode            (opcode),
		.point_x_mm        (point_x_mm),
		.point_y_mm        (point_y_mm),
		.point_z_mm        (point_z_mm),
		.point_finite      (point_finite),
		.read_index        (read_index),
		.col_coeffs        (col_coeffs_q),
		.row_coeffs        (row_coeffs_q),
		.col_offset        (col_offset_q),
		.row_offset        (row_offset_q),
		.ground_limit_mm   (ground_lim_q),
		.obstacle_limit_mm (obst_lim_q),
		.item              (item)
	);

	// Stage 5 inputs: bounds check and cell address
	logic                       col_ok, row_ok, inb, rd_ok;
	logic [ogu_pkg::ADDR_W-1:0] pt_addr, addr_n;
	logic [ogu_pkg::IDX_W-1:0]  cidx_n;

	assign col_ok = !item.col[ogu_pkg::COORD_W-1]
		&& ($unsigned(item.col) < ogu_pkg::COORD_W'(ogu_pkg::GRID_COLS));
	assign row_ok = !item.row[ogu_pkg::COORD_W-1]
		&& ($unsigned(item.row) < ogu_pkg::COORD_W'(ogu_pkg::GRID_ROWS));
	assign inb     = col_ok && row_ok;
	assign pt_addr = ogu_pkg::ADDR_W'($unsigned(item.row))
		* ogu_pkg::ADDR_W'(ogu_pkg::GRID_COLS) + ogu_pkg::ADDR_W'($unsigned(item.col));
	assign rd_ok   = 32'(item.ridx) < 32'(ogu_pkg::GRID_CELLS);
	assign addr_n  = (item.op == ogu_pkg::OP_READ) ? ogu_pkg::ADDR_W'(item.ridx) : pt_addr;
	assign cidx_n  = (item.op == ogu_pkg::OP_READ) ? item.ridx : ogu_pkg::IDX_W'(pt_addr);

	logic                       v_s5, op_s5, fin_s5, cls_s5, obst_s5, inb_s5, rdok_s5;
	logic [ogu_pkg::ADDR_W-1:0] addr_s5;
	logic [ogu_pkg::IDX_W-1:0]  cidx_s5;

	logic                       v_s6, op_s6, fin_s6, cls_s6, obst_s6, inb_s6, rdok_s6;
	logic [ogu_pkg::ADDR_W-1:0] addr_s6;
	logic [ogu_pkg::IDX_W-1:0]  cidx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s5 <= item.valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5   <= item.op;
			fin_s5  <= item.fin;
			cls_s5  <= item.ground || item.obst;
			obst_s5 <= item.obst;
			inb_s5  <= inb;
			rdok_s5 <= rd_ok;
			addr_s5 <= addr_n;
			cidx_s5 <= cidx_n;

			op_s6   <= op_s5;
			fin_s6  <= fin_s5;
			cls_s6  <= cls_s5;
			obst_s6 <= obst_s5;
			inb_s6  <= inb_s5;
			rdok_s6 <= rdok_s5;
			addr_s6 <= addr_s5;
			cidx_s6 <= cidx_s5;
		end
	end

	// Grid memory: read issued from stage 5, written from stage 6
	ogu_pkg::grid_req_t         greq;
	logic [ogu_pkg::CELL_W-1:0] grd_data;
	logic                       upd_we;
	logic [ogu_pkg::CELL_W-1:0] upd_val;

	assign greq.rd_en   = adv;
	assign greq.rd_addr = addr_s5;
	assign greq.wr_en   = adv && v_s6 && upd_we;
	assign greq.wr_addr = addr_s6;
	assign greq.wr_data = upd_val;

	ogu_grid u_grid (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (greq),
		.rd_data  (grd_data),
		.clearing (clearing)
	);

	// Last write, forwarded over the read that overlapped it
	logic                       fwd_valid_q;
	logic [ogu_pkg::ADDR_W-1:0] fwd_addr_q;
	logic [ogu_pkg::CELL_W-1:0] fwd_val_q;
	logic [ogu_pkg::CELL_W-1:0] cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (greq.wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (greq.wr_en) begin
			fwd_addr_q <= addr_s6;
			fwd_val_q  <= upd_val;
		end
	end

	assign cur = (fwd_valid_q && fwd_addr_q == addr_s6) ? fwd_val_q : grd_data;

	// Stage 6: cell update and result
	logic [ogu_pkg::STATUS_W-1:0] st_n;
	logic [ogu_pkg::CELL_W-1:0]   cv_n;
	logic [ogu_pkg::IDX_W-1:0]    ci_n;
	logic                         inc_proc, inc_free, inc_obst;

	always_comb begin
		st_n     = ogu_pkg::ST_SKIPPED;
		cv_n     = ogu_pkg::CELL_UNKNOWN;
		ci_n     = '0;
		upd_we   = 1'b0;
		upd_val  = cur;
		inc_proc = 1'b0;
		inc_free = 1'b0;
		inc_obst = 1'b0;
		if (op_s6 == ogu_pkg::OP_READ) begin
			st_n = ogu_pkg::ST_READ;
			ci_n = cidx_s6;
			cv_n = rdok_s6 ? cur : ogu_pkg::CELL_UNKNOWN;
		end else if (fin_s6) begin
			inc_proc = 1'b1;
			if (!cls_s6) begin
				st_n = ogu_pkg::ST_SKIPPED;
			end else if (!inb_s6) begin
				st_n = ogu_pkg::ST_OUT_OF_BOUNDS;
			end else if (obst_s6) begin
				upd_we   = 1'b1;
				upd_val  = ogu_pkg::CELL_OCCUPIED;
				inc_obst = 1'b1;
				st_n     = ogu_pkg::ST_OCCUPIED;
				cv_n     = ogu_pkg::CELL_OCCUPIED;
				ci_n     = cidx_s6;
			end else if (cur == ogu_pkg::CELL_UNKNOWN) begin
				upd_we   = 1'b1;
				upd_val  = ogu_pkg::CELL_FREE;
				inc_free = 1'b1;
				st_n     = ogu_pkg::ST_FREE;
				cv_n     = ogu_pkg::CELL_FREE;
				ci_n     = cidx_s6;
			end else begin
				st_n = ogu_pkg::ST_UNCHANGED;
				cv_n = cur;
				ci_n = cidx_s6;
			end
		end
	end

	// Saturating counters
	logic [ogu_pkg::CNT_W-1:0] cnt_proc_q, cnt_free_q, cnt_obst_q;
	logic [ogu_pkg::CNT_W-1:0] proc_n, free_n, obst_n;

	assign proc_n = cnt_proc_q + ogu_pkg::CNT_W'(inc_proc && (cnt_proc_q != '1));
	assign free_n = cnt_free_q + ogu_pkg::CNT_W'(inc_free && (cnt_free_q != '1));
	assign obst_n = cnt_obst_q + ogu_pkg::CNT_W'(inc_obst && (cnt_obst_q != '1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_proc_q <= '0;
			cnt_free_q <= '0;
			cnt_obst_q <= '0;
		end else if (adv && v_s6) begin
			cnt_proc_q <= proc_n;
			cnt_free_q <= free_n;
			cnt_obst_q <= obst_n;
		end
	end

	// Output register
	logic [ogu_pkg::STATUS_W-1:0] status_q;
	logic [ogu_pkg::IDX_W-1:0]    cidx_q;
	logic [ogu_pkg::CELL_W-1:0]   cval_q;
	logic [ogu_pkg::CNT_W-1:0]    oproc_q, ofree_q, oobst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			status_q <= st_n;
			cidx_q   <= ci_n;
			cval_q   <= cv_n;
			oproc_q  <= proc_n;
			ofree_q  <= free_n;
			oobst_q  <= obst_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign cell_index       = cidx_q;
	assign cell_value       = cval_q;
	assign points_processed = oproc_q;
	assign ground_updates   = ofree_q;
	assign obstacle_updates = oobst_q;

	a_proc_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_proc_q >= $past(cnt_proc_q))
		else $error("processed count went down");

	a_free_le_proc: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_free_q <= cnt_proc_q)
		else $error("more free marks than processed points");

	a_occ_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ogu_pkg::ST_OCCUPIED |-> cval_q == ogu_pkg::CELL_OCCUPIED)
		else $error("occupied status without occupied cell value");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !v_s6 && !greq.wr_en)
		else $error("item in flight during grid clear pass");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the occupancy grid core: directed table, then random traffic against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ogu_pkg::*;

	// One request on the input channel
	typedef struct packed {
		logic                    op;
		logic signed [MM_W-1:0]  x;
		logic signed [MM_W-1:0]  y;
		logic signed [MM_W-1:0]  z;
		logic                    fin;
		logic [IDX_W-1:0]        ridx;
	} point_req_t;

	// One result on the output channel
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    cidx;
		logic [CELL_W-1:0]   cval;
		logic [CNT_W-1:0]    pp;
		logic [CNT_W-1:0]    gu;
		logic [CNT_W-1:0]    ob;
	} cell_report_t;

	// Directed row: request plus an optional typed-in result
	typedef struct packed {
		point_req_t   req;
		logic         typed;
		cell_report_t want;
	} table_row_t;

	localparam int DRAIN_CYCLES = 12;
	localparam int REPORT_CAP   = 200;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic                     opcode;
	logic signed [MM_W-1:0]   point_x_mm;
	logic signed [MM_W-1:0]   point_y_mm;
	logic signed [MM_W-1:0]   point_z_mm;
	logic                     point_finite;
	logic [IDX_W-1:0]         read_index;
	logic                     out_valid;
	logic                     out_stall;
	logic [STATUS_W-1:0]      status;
	logic [IDX_W-1:0]         cell_index;
	logic [CELL_W-1:0]        cell_value;
	logic [CNT_W-1:0]         points_processed;
	logic [CNT_W-1:0]         ground_updates;
	logic [CNT_W-1:0]         obstacle_updates;

	point_to_occupancy_grid_update_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.point_x_mm       (point_x_mm),
		.point_y_mm       (point_y_mm),
		.point_z_mm       (point_z_mm),
		.point_finite     (point_finite),
		.read_index       (read_index),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.cell_index       (cell_index),
		.cell_value       (cell_value),
		.points_processed (points_processed),
		.ground_updates   (ground_updates),
		.obstacle_updates (obstacle_updates)
	);

	// Predictor state: grid, counters and a copy of the registers
	bit [CELL_W-1:0]          grid_state [0:GRID_CELLS-1];
	bit [CNT_W-1:0]           processed_cnt;
	bit [CNT_W-1:0]           free_cnt;
	bit [CNT_W-1:0]           obst_cnt;
	logic [CFG_W-1:0]         col_coefs_cfg = RST_COL_COEFFS;
	logic [CFG_W-1:0]         row_coefs_cfg = RST_ROW_COEFFS;
	logic signed [OFFS_W-1:0] col_offs_cfg  = RST_COL_OFFSET;
	logic signed [OFFS_W-1:0] row_offs_cfg  = RST_ROW_OFFSET;
	logic signed [MM_W-1:0]   ground_lim_cfg = RST_GROUND_LIM;
	logic signed [MM_W-1:0]   obst_lim_cfg   = RST_OBST_LIM;

	cell_report_t             cell_expect_q [$];
	table_row_t               directed_tab [$];
	int                       mismatch_cnt;
	int                       send_pct;
	int                       recv_pct;
	int                       send_quiet;
	int                       recv_quiet;
	logic signed [MM_W-1:0]   last_x;
	logic signed [MM_W-1:0]   last_y;
	logic [IDX_W-1:0]         last_cell;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: sweep after reset plus a slow run, several times over
	initial begin
		#15_000_000;
		$display("point_to_occupancy_grid_update_core: mismatch");
		$finish;
	end

	function automatic bit [CNT_W-1:0] count_up(input bit [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Cell coordinate: round half away from zero of the 2^-16 accumulator
	function automatic longint project_cells(input logic [CFG_W-1:0] coefs,
			input logic signed [OFFS_W-1:0] offs, input longint x, input longint y,
			input longint z);
		longint cx;
		longint cy;
		longint cz;
		longint acc;
		cx = $signed(coefs[15:0]);
		cy = $signed(coefs[31:16]);
		cz = $signed(coefs[47:32]);
		acc = cx * x + cy * y + cz * z + longint'(offs) * 256;
		if (acc >= 0)
			return (acc + 32768) >>> 16;
		return -((-acc + 32768) >>> 16);
	endfunction

	// Applies one request to the predicted grid and returns its result
	function automatic cell_report_t apply_request(input point_req_t r);
		cell_report_t res;
		longint       col;
		longint       row;
		longint       idx;
		bit           is_ground;
		bit           is_obst;
		res = '0;
		res.status = ST_SKIPPED;
		if (r.op == OP_READ) begin
			res.status = ST_READ;
			res.cidx = r.ridx;
			res.cval = grid_state[r.ridx];
		end else if (r.fin) begin
			is_ground = (r.z < ground_lim_cfg) && (r.z > FLOOR_LIMIT_MM);
			is_obst = r.z > obst_lim_cfg;
			processed_cnt = count_up(processed_cnt);
			if (is_ground || is_obst) begin
				col = project_cells(col_coefs_cfg, col_offs_cfg, r.x, r.y, r.z);
				row = project_cells(row_coefs_cfg, row_offs_cfg, r.x, r.y, r.z);
				if (col < 0 || col >= longint'(GRID_COLS) || row < 0 ||
						row >= longint'(GRID_ROWS)) begin
					res.status = ST_OUT_OF_BOUNDS;
				end else begin
					idx = row * longint'(GRID_COLS) + col;
					// obstacle wins over ground; ground only claims unknown cells
					if (is_obst) begin
						grid_state[idx] = CELL_OCCUPIED;
						obst_cnt = count_up(obst_cnt);
						res.status = ST_OCCUPIED;
					end else if (grid_state[idx] == CELL_UNKNOWN) begin
						grid_state[idx] = CELL_FREE;
						free_cnt = count_up(free_cnt);
						res.status = ST_FREE;
					end else begin
						res.status = ST_UNCHANGED;
					end
					res.cidx = idx[IDX_W-1:0];
					res.cval = grid_state[idx];
					last_cell = idx[IDX_W-1:0];
				end
			end
		end
		res.pp = processed_cnt;
		res.gu = free_cnt;
		res.ob = obst_cnt;
		return res;
	endfunction

	// Random request: mostly well-formed points near the configured grid
	function automatic point_req_t random_request();
		point_req_t r;
		int         pick;
		r.op = OP_INSERT;
		r.fin = 1'b1;
		r.x = $urandom;
		r.y = $urandom;
		r.z = $urandom;
		r.ridx = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			r.op = OP_READ;
			if ($urandom_range(0, 1))
				r.ridx = last_cell;
		end else if (pick < 15) begin
			r.fin = 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				// same spot again: back-to-back hits on one cell
				r.x = last_x;
				r.y = last_y;
			end else if (pick < 45) begin
				r.x = last_x + int'($urandom_range(0, 100)) - 50;
				r.y = last_y + int'($urandom_range(0, 100)) - 50;
			end else if (pick < 85) begin
				r.x = int'($urandom_range(0, 8000)) - 4000;
				r.y = int'($urandom_range(0, 8000)) - 4000;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r.z = int'($urandom_range(0, 2400)) - 1200;
			else if (pick < 55)
				r.z = ground_lim_cfg + int'($urandom_range(0, 4)) - 2;
			else if (pick < 70)
				r.z = obst_lim_cfg + int'($urandom_range(0, 4)) - 2;
			else if (pick < 80)
				r.z = FLOOR_LIMIT_MM + int'($urandom_range(0, 4)) - 2;
			else if (pick < 85)
				r.z = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			last_x = r.x;
			last_y = r.y;
		end
		return r;
	endfunction

	// Idle decision with occasional quiet stretches
	function automatic bit idle_now(input int pct, inout int quiet);
		if (pct == 0)
			return 1'b0;
		if (quiet > 0) begin
			quiet--;
			return 1'b0;
		end
		if ($urandom_range(0, 99) == 0) begin
			quiet = $urandom_range(10, 40);
			return 1'b0;
		end
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_CAP)
			$display("ERROR %s: got %0d, want %0d at %0t", what, got, want, $time);
	endtask

	task automatic add_row(input logic op, input int x, input int y, input int z,
			input logic fin, input int ridx, input logic typed, input logic [2:0] st,
			input int cidx, input logic [1:0] cval, input int pp, input int gu,
			input int ob);
		table_row_t t;
		t.req = '{op: op, x: x[15:0], y: y[15:0], z: z[15:0], fin: fin, ridx: ridx[17:0]};
		t.typed = typed;
		t.want = '{status: st, cidx: cidx[17:0], cval: cval, pp: pp, gu: gu, ob: ob};
		directed_tab.push_back(t);
	endtask

	// Register write; the predictor copy follows at once
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_COL_COEFFS: col_coefs_cfg = data;
			REG_ROW_COEFFS: row_coefs_cfg = data;
			REG_COL_OFFSET: col_offs_cfg = data[31:0];
			REG_ROW_OFFSET: row_offs_cfg = data[31:0];
			REG_GROUND_LIM: ground_lim_cfg = data[15:0];
			REG_OBST_LIM:   obst_lim_cfg = data[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Phase 1 and 4 use extreme register values, the rest a sane random map
	task automatic configure_phase(input int ph);
		int cx;
		int cy;
		int cz;
		int rx;
		int ry;
		int rz;
		int co;
		int ro;
		int g;
		int o;
		if (ph == 1) begin
			// column pinned to 0, rows near 200, nearly everything an obstacle
			write_reg(REG_COL_COEFFS, 48'h0000_0000_0000);
			write_reg(REG_ROW_COEFFS, 48'hFFFF_FFFF_FFFF);
			write_reg(REG_COL_OFFSET, 48'hFFFF_FFFF_FFFF);
			write_reg(REG_ROW_OFFSET, 48'h0000_0000_C800);
			write_reg(REG_GROUND_LIM, 48'h0000_0000_7FFF);
			write_reg(REG_OBST_LIM,   48'hFFFF_FFFF_8000);
		end else if (ph == 4) begin
			// extreme offsets: every classed point falls off the grid
			write_reg(REG_COL_COEFFS, 48'h7FFF_8000_7FFF);
			write_reg(REG_ROW_COEFFS, 48'h8000_7FFF_8000);
			write_reg(REG_COL_OFFSET, 48'h0000_7FFF_FFFF);
			write_reg(REG_ROW_OFFSET, 48'hFFFF_8000_0000);
			write_reg(REG_GROUND_LIM, 48'hFFFF_FFFF_8000);
			write_reg(REG_OBST_LIM,   48'h0000_0000_7FFE);
		end else begin
			cx = $urandom_range(400, 4000);
			if ($urandom_range(0, 1))
				cx = -cx;
			cy = int'($urandom_range(0, 4000)) - 2000;
			cz = int'($urandom_range(0, 200)) - 100;
			ry = $urandom_range(400, 4000);
			if ($urandom_range(0, 1))
				ry = -ry;
			rx = int'($urandom_range(0, 4000)) - 2000;
			rz = int'($urandom_range(0, 200)) - 100;
			co = (192 + int'($urandom_range(0, 128))) * 256 + int'($urandom_range(0, 255));
			ro = (192 + int'($urandom_range(0, 128))) * 256 + int'($urandom_range(0, 255));
			g = int'($urandom_range(0, 1000)) - 500;
			o = g + int'($urandom_range(0, 400)) - 100;
			write_reg(REG_COL_COEFFS, {cz[15:0], cy[15:0], cx[15:0]});
			write_reg(REG_ROW_COEFFS, {rz[15:0], ry[15:0], rx[15:0]});
			write_reg(REG_COL_OFFSET, {{16{co[31]}}, co});
			write_reg(REG_ROW_OFFSET, {{16{ro[31]}}, ro});
			write_reg(REG_GROUND_LIM, {{32{g[15]}}, g[15:0]});
			write_reg(REG_OBST_LIM,   {{32{o[15]}}, o[15:0]});
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One transfer on the input channel, then queue what it should produce
	task automatic send_item(input point_req_t r, input logic typed, input cell_report_t want);
		cell_report_t got_pred;
		while (idle_now(send_pct, send_quiet)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		point_x_mm <= r.x;
		point_y_mm <= r.y;
		point_z_mm <= r.z;
		point_finite <= r.fin;
		read_index <= r.ridx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got_pred = apply_request(r);
		cell_expect_q.push_back(typed ? want : got_pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cell_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stall and field-by-field check
	always @(posedge clk) begin : result_check
		cell_report_t want;
		if (out_valid && !out_stall) begin
			if (cell_expect_q.size() == 0) begin
				report_mismatch("result with nothing pending, status", status, 0);
			end else begin
				want = cell_expect_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (cell_index !== want.cidx)
					report_mismatch("cell_index", cell_index, want.cidx);
				if (cell_value !== want.cval)
					report_mismatch("cell_value", cell_value, want.cval);
				if (points_processed !== want.pp)
					report_mismatch("points_processed", points_processed, want.pp);
				if (ground_updates !== want.gu)
					report_mismatch("ground_updates", ground_updates, want.gu);
				if (obstacle_updates !== want.ob)
					report_mismatch("obstacle_updates", obstacle_updates, want.ob);
			end
		end
		out_stall <= idle_now(recv_pct, recv_quiet);
	end

	initial begin : stimulus
		int ph;
		int n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		opcode <= OP_INSERT;
		point_x_mm <= '0;
		point_y_mm <= '0;
		point_z_mm <= '0;
		point_finite <= 1'b0;
		read_index <= '0;
		out_stall <= 1'b0;
		mismatch_cnt = 0;
		send_pct = 31;
		recv_pct = 61;
		send_quiet = 0;
		recv_quiet = 0;
		last_x = '0;
		last_y = '0;
		last_cell = '0;

		// Reset register values: 1311/65536 cells per mm, origin at cell (256, 256)
		add_row(OP_READ, 0, 0, 0, 0, 0, 1, ST_READ, 0, CELL_UNKNOWN, 0, 0, 0);
		add_row(OP_READ, -1, -1, -1, 1, 262143, 1, ST_READ, 262143, CELL_UNKNOWN, 0, 0, 0);
		add_row(OP_INSERT, 32767, 32767, 0, 0, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 0, 0, 0);
		add_row(OP_INSERT, 0, 0, 200, 1, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 1, 0, 0);
		add_row(OP_INSERT, 0, 0, 0, 1, 0, 1, ST_FREE, 131328, CELL_FREE, 2, 1, 0);
		add_row(OP_INSERT, 0, 0, 0, 1, 0, 1, ST_UNCHANGED, 131328, CELL_FREE, 3, 1, 0);
		add_row(OP_INSERT, 0, 0, 1000, 1, 0, 1, ST_OCCUPIED, 131328, CELL_OCCUPIED, 4, 1, 1);
		add_row(OP_INSERT, 0, 0, 0, 1, 0, 1, ST_UNCHANGED, 131328, CELL_OCCUPIED, 5, 1, 1);
		add_row(OP_READ, 0, 0, 0, 0, 131328, 1, ST_READ, 131328, CELL_OCCUPIED, 5, 1, 1);
		// floor limit is exclusive, so this point is not classed and is skipped
		add_row(OP_INSERT, 0, 0, -1000, 1, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 6, 1, 1);
		add_row(OP_INSERT, 0, 0, -999, 1, 0, 1, ST_UNCHANGED, 131328, CELL_OCCUPIED, 7, 1, 1);
		add_row(OP_INSERT, 0, 0, 150, 1, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 8, 1, 1);
		add_row(OP_INSERT, 0, 0, 250, 1, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 9, 1, 1);
		add_row(OP_INSERT, 32767, 0, 251, 1, 0, 1, ST_OUT_OF_BOUNDS, 0, CELL_UNKNOWN,
			10, 1, 1);
		add_row(OP_INSERT, -32768, -32768, 32767, 1, 0, 1, ST_OUT_OF_BOUNDS, 0,
			CELL_UNKNOWN, 11, 1, 1);
		add_row(OP_INSERT, 0, 0, -32768, 1, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 12, 1, 1);
		add_row(OP_INSERT, 0, 0, 0, 0, 0, 1, ST_SKIPPED, 0, CELL_UNKNOWN, 12, 1, 1);
		add_row(OP_READ, 32767, 0, 0, 1, 131329, 1, ST_READ, 131329, CELL_UNKNOWN, 12, 1, 1);
		// grid corners and the first column past the edge
		add_row(OP_INSERT, -12798, -12798, -999, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 12747, 12747, 149, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 12747, -12798, 32767, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 12773, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ, 0, 0, 0, 0, 262143, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset register values; first transfer waits out the sweep
		foreach (directed_tab[i])
			send_item(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].want);
		drain();

		// Random phases, each with its own register setting
		for (ph = 0; ph < 8; ph++) begin
			if (ph < 2) begin
				send_pct = 31;
				recv_pct = 61;
			end else if (ph < 5) begin
				send_pct = 61;
				recv_pct = 31;
			end else begin
				send_pct = 0;
				recv_pct = 0;
			end
			configure_phase(ph);
			n = (ph == 1) ? 150 : (ph == 4) ? 80 : 260;
			repeat (n) send_item(random_request(), 1'b0, '0);
			drain();
		end

		if (mismatch_cnt == 0)
			$display("point_to_occupancy_grid_update_core: match");
		else
			$display("point_to_occupancy_grid_update_core: mismatch");
		$finish;
	end

endmodule
